### rtl/med_pkg.sv
// Package: shared types, constants and state encoding of the masked Euclidean distance block.
`default_nettype none
package med_pkg;

   localparam int ITEMS_MAX   = 4096;
   localparam int RATING_BITS = 8;

   localparam int RATING_W = 8;
   localparam int THRESH_W = 13;
   localparam int COUNT_W  = 13;
   localparam int DIST_W   = 23;
   localparam int SUM_W    = 28;
   localparam int SQ_W     = 2 * RATING_W;

   // Count saturates at the smaller of the item limit and the field maximum.
   localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
   localparam int COUNT_CAP_INT   = (ITEMS_MAX < COUNT_FIELD_MAX) ? ITEMS_MAX : COUNT_FIELD_MAX;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_CAP_INT[COUNT_W-1:0];

   localparam int RATING_USE = (RATING_BITS < RATING_W) ? RATING_BITS : RATING_W;
   localparam logic [RATING_W-1:0] RATING_MASK = RATING_W'((1 << RATING_USE) - 1);

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);

   // Root of (sum << 16): 44-bit radicand, 22-bit root, two radicand bits per step.
   localparam int FRAC_BITS = 16;
   localparam int RAD_W     = SUM_W + FRAC_BITS;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int ITER      = ROOT_W;
   localparam int ITER_W    = $clog2(ITER + 1);

   typedef struct packed {
      logic [RATING_W-1:0] rating_a;
      logic [RATING_W-1:0] rating_b;
      logic                last_item;
   } req_payload_type;

   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [COUNT_W-1:0] common_items;
      logic               enough_overlap;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
   } sqrt_ctl_type;

   typedef struct packed {
      logic busy;
   } sqrt_stat_type;

   typedef enum logic {
      ST_ACCUM,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

### rtl/med_accum.sv
// Accumulator: running sum of squared rating differences and co-rated item count.
`default_nettype none
module med_accum
   import med_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire req_payload_type      item,
   output logic      [SUM_W-1:0]     sum_next,
   output logic      [COUNT_W-1:0]   count_next
);

   logic [SUM_W-1:0]   sum_ff,   sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [RATING_W-1:0] a, b, diff;
   logic [SQ_W-1:0]     sq;
   logic [SUM_W:0]      total;
   logic                both;

   always_comb begin
      a    = item.rating_a & RATING_MASK;
      b    = item.rating_b & RATING_MASK;
      both = (a != '0) && (b != '0);
      diff = (a > b) ? (a - b) : (b - a);
      sq   = SQ_W'(diff) * SQ_W'(diff);
      total = {1'b0, sum_ff} + (SUM_W + 1)'(sq);

      sum_next   = sum_ff;
      count_next = count_ff;
      if (both) begin
         // saturate at all ones
         sum_next = total[SUM_W] ? '1 : total[SUM_W-1:0];
         if (count_ff < COUNT_CAP) begin
            count_next = count_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (item.last_item) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/med_sqrt.sv
// Iterative square root: one compare and subtract per cycle, two radicand bits a step.
`default_nettype none
module med_sqrt
   import med_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sqrt_ctl_type        ctl,
   input  wire logic    [SUM_W-1:0] sum,
   output sqrt_stat_type            stat,
   output logic         [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ITER_W-1:0] cnt_ff,  cnt_in;

   logic [REM_W+1:0] work, trial, diff;
   logic             fits;

   always_comb begin
      work  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({root_ff, 2'b01});
      diff  = work - trial;
      fits  = work >= trial;

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         rad_in  = {sum, FRAC_BITS'(0)};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = ITER_W'(ITER);
      end else if (cnt_ff != '0) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = fits ? diff[REM_W-1:0] : work[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign root      = root_ff;

   property p_start_busy;
      @(posedge clock) disable iff (reset) ctl.start |=> stat.busy;
   endproperty
   a_start_busy: assert property (p_start_busy)
      else $error("root unit not busy after start");

endmodule
`default_nettype wire

### rtl/masked_euclidean_distance_top.sv
// Top level: sequencer, threshold register and output register of the distance block.
//
// Usage
//   req_*  : one rating pair per transaction (rating_a, rating_b, last_item).
//            A rating of 0 means unrated; only pairs with both ratings nonzero
//            add their squared difference and count as a common item.
//   rsp_*  : one transaction per user pair, sent after its last item:
//            distance (unsigned Q15.8, truncated), common_items, enough_overlap.
//   csr_*  : threshold write, count must exceed it; takes effect on the next last item.
// Throughput
//   Non-last items are taken one per cycle. A last item with enough overlap
//   starts a 22-step root (one remainder compare/subtract per cycle in the
//   root unit); when the root is done and the output register is free, the
//   result is loaded into it. Without enough overlap the zero result is
//   loaded from the finish state once the register is free. req_ready is
//   low from the last item until its result sits in the output register.
// Stall
//   The output register holds a result while rsp_ready is low; new items are
//   still taken, but a finished root waits until the register frees up.
// Reset
//   Synchronous, active high: sums, counts and pending results clear, the
//   threshold returns to 1.
`default_nettype none
module masked_euclidean_distance_top
   import med_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_payload_type      req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  wire logic                 csr_write_enable,
   input  wire logic  [THRESH_W-1:0] csr_write_data
);

   state_type state_ff, state_in;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                enough_ff, enough_in;
   logic [COUNT_W-1:0]  count_res_ff, count_res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic [SUM_W-1:0]   sum_next;
   logic [COUNT_W-1:0] count_next;
   logic [ROOT_W-1:0]  root;
   sqrt_ctl_type       sqrt_ctl;
   sqrt_stat_type      sqrt_stat;

   logic accept, last_accept, out_free, finish_go, enough_now;

   med_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .item       (req_payload),
      .sum_next   (sum_next),
      .count_next (count_next)
   );

   med_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .ctl   (sqrt_ctl),
      .sum   (sum_next),
      .stat  (sqrt_stat),
      .root  (root)
   );

   // handshake and sequencing terms
   assign accept      = req_valid && req_ready;
   assign last_accept = accept && req_payload.last_item;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign enough_now  = count_next > COUNT_W'(thresh_ff);
   assign finish_go   = (state_ff == ST_FINISH) && !sqrt_stat.busy && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (last_accept) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready      = 1'b0;
      sqrt_ctl.start = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_ready      = 1'b1;
            sqrt_ctl.start = last_accept && enough_now;
         end
         ST_FINISH: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // pair result capture and output register
   always_comb begin
      thresh_in    = csr_write_enable ? csr_write_data : thresh_ff;
      enough_in    = last_accept ? enough_now : enough_ff;
      count_res_in = last_accept ? count_next : count_res_ff;

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (finish_go) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.distance       = enough_ff ? DIST_W'(root) : '0;
         rsp_data_in.common_items   = count_res_ff;
         rsp_data_in.enough_overlap = enough_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         thresh_ff    <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      enough_ff    <= enough_in;
      count_res_ff <= count_res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // checks
   property p_zero_when_short;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_payload.enough_overlap) |-> (rsp_payload.distance == '0);
   endproperty
   a_zero_when_short: assert property (p_zero_when_short)
      else $error("nonzero distance without enough overlap");

   property p_last_blocks;
      @(posedge clock) disable iff (reset)
         (req_valid && req_ready && req_payload.last_item) |=> !req_ready;
   endproperty
   a_last_blocks: assert property (p_last_blocks)
      else $error("input taken right after a last item");

   property p_busy_not_ready;
      @(posedge clock) disable iff (reset) sqrt_stat.busy |-> !req_ready;
   endproperty
   a_busy_not_ready: assert property (p_busy_not_ready)
      else $error("input ready while root in progress");

   property p_result_held;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload));
   endproperty
   a_result_held: assert property (p_result_held)
      else $error("stalled result dropped or changed");

endmodule
`default_nettype wire
